@@ rtl/core/dmwb_pkg.sv @@
// ----------------------------------------------------------------------------
// dmwb_pkg
// Shared sizes and controller/datapath interface types for the
// direct-mapped write-back cache core.
// ----------------------------------------------------------------------------
package dmwb_pkg;

  localparam int ADDR_W      = 11;                     // byte address
  localparam int DATA_W      = 8;                      // one byte
  localparam int OFF_W       = 4;                      // byte within line
  localparam int IDX_W       = 4;                      // line index
  localparam int TAG_W       = ADDR_W - OFF_W - IDX_W;
  localparam int LINE_SIZE   = 2 ** OFF_W;
  localparam int NUM_LINES   = 2 ** IDX_W;
  localparam int MEM_SIZE    = 2 ** ADDR_W;
  localparam int CACHE_AW    = IDX_W + OFF_W;
  localparam int CACHE_BYTES = 2 ** CACHE_AW;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic req_load;    // latch the accepted request
    logic init_step;   // write one backing byte of the power-up pattern
    logic lookup;      // hit access: read slot, write it on a store
    logic spill_step;  // read one victim byte (written back in the next cycle)
    logic fill_step;   // read one backing byte (written to the line in the next cycle)
    logic fill_end;    // install tag, set valid, clear dirty
    logic out_load;    // capture the result into the output register
  } dmwb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;          // valid line with matching tag
    logic victim_dirty; // line at index is valid and dirty
    logic cnt_last;     // line byte counter at its last byte
    logic init_last;    // power-up pass at its last byte
  } dmwb_sts_t;

endpackage

@@ rtl/core/dmwb_ctrl.sv @@
// ----------------------------------------------------------------------------
// dmwb_ctrl
// Controller state machine: power-up pass, lookup, write-back, line fill
// and result hand-off.
// ----------------------------------------------------------------------------
module dmwb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  dmwb_pkg::dmwb_sts_t sts,
  output dmwb_pkg::dmwb_cmd_t cmd
);

  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_LOOKUP   = 3'd2;
  localparam logic [2:0] S_SPILL    = 3'd3;
  localparam logic [2:0] S_FILL     = 3'd4;
  localparam logic [2:0] S_FILL_END = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) || ((state_r == S_RESP) && out_free);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.req_load = accept;
    unique case (state_r)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (sts.hit) begin
          cmd.lookup = 1'b1;
          state_nxt  = S_RESP;
        end else if (sts.victim_dirty) begin
          state_nxt = S_SPILL;
        end else begin
          state_nxt = S_FILL;
        end
      end
      S_SPILL: begin
        cmd.spill_step = 1'b1;
        if (sts.cnt_last) state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.cnt_last) state_nxt = S_FILL_END;
      end
      S_FILL_END: begin
        cmd.fill_end = 1'b1;
        state_nxt    = S_LOOKUP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = accept ? S_LOOKUP : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/dmwb_datapath.sv @@
// ----------------------------------------------------------------------------
// dmwb_datapath
// Request registers, tag/valid/dirty arrays, line data RAM, backing RAM,
// line byte counter and output register.
// ----------------------------------------------------------------------------
module dmwb_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dmwb_pkg::dmwb_cmd_t         cmd,
  output dmwb_pkg::dmwb_sts_t         sts,
  input  logic                        in_cmd,
  input  logic [dmwb_pkg::ADDR_W-1:0] in_address,
  input  logic [dmwb_pkg::DATA_W-1:0] in_write_data,
  output logic [dmwb_pkg::DATA_W-1:0] out_read_data,
  output logic                        out_hit
);

  localparam int ADDR_W   = dmwb_pkg::ADDR_W;
  localparam int DATA_W   = dmwb_pkg::DATA_W;
  localparam int OFF_W    = dmwb_pkg::OFF_W;
  localparam int IDX_W    = dmwb_pkg::IDX_W;
  localparam int TAG_W    = dmwb_pkg::TAG_W;
  localparam int CACHE_AW = dmwb_pkg::CACHE_AW;
  localparam int NLINES   = dmwb_pkg::NUM_LINES;

  // request
  logic              req_cmd_r;
  logic [ADDR_W-1:0] req_addr_r;
  logic [DATA_W-1:0] req_wdata_r;
  logic [OFF_W-1:0]  req_off;
  logic [IDX_W-1:0]  req_idx;
  logic [TAG_W-1:0]  req_tag;

  assign req_off = req_addr_r[OFF_W-1:0];
  assign req_idx = req_addr_r[OFF_W+IDX_W-1:OFF_W];
  assign req_tag = req_addr_r[ADDR_W-1:OFF_W+IDX_W];

  // line state
  logic [TAG_W-1:0]  tags_r [NLINES];
  logic [NLINES-1:0] valid_r;
  logic [NLINES-1:0] dirty_r;
  logic              miss_r;

  // sequencing
  logic [OFF_W-1:0]  cnt_r;
  logic [OFF_W-1:0]  off_d_r;
  logic              spill_wr_r;
  logic              fill_wr_r;
  logic [ADDR_W-1:0] init_cnt_r;

  // memories
  logic [DATA_W-1:0] cache_mem [dmwb_pkg::CACHE_BYTES];
  logic [DATA_W-1:0] back_mem  [dmwb_pkg::MEM_SIZE];
  logic [DATA_W-1:0] cache_rdata_r;
  logic [DATA_W-1:0] back_rdata_r;

  logic                cache_re, cache_we;
  logic [CACHE_AW-1:0] cache_raddr, cache_waddr;
  logic [DATA_W-1:0]   cache_wdata;
  logic                back_re, back_we;
  logic [ADDR_W-1:0]   back_raddr, back_waddr;
  logic [DATA_W-1:0]   back_wdata;

  logic [DATA_W-1:0] out_data_r;
  logic              out_hit_r;

  assign sts.hit          = valid_r[req_idx] && (tags_r[req_idx] == req_tag);
  assign sts.victim_dirty = valid_r[req_idx] && dirty_r[req_idx];
  assign sts.cnt_last     = (cnt_r == OFF_W'(dmwb_pkg::LINE_SIZE - 1));
  assign sts.init_last    = (init_cnt_r == ADDR_W'(dmwb_pkg::MEM_SIZE - 1));

  // line RAM ports
  always_comb begin
    cache_re    = cmd.lookup || cmd.spill_step;
    cache_raddr = cmd.spill_step ? {req_idx, cnt_r} : {req_idx, req_off};
    cache_we    = fill_wr_r || (cmd.lookup && (req_cmd_r == dmwb_pkg::CMD_WRITE));
    cache_waddr = fill_wr_r ? {req_idx, off_d_r} : {req_idx, req_off};
    cache_wdata = fill_wr_r ? back_rdata_r : req_wdata_r;
  end

  // backing RAM ports; each write-back byte is written in the cycle after its line read
  always_comb begin
    back_re    = cmd.fill_step;
    back_raddr = {req_tag, req_idx, cnt_r};
    back_we    = cmd.init_step || spill_wr_r;
    back_waddr = cmd.init_step ? init_cnt_r : {tags_r[req_idx], req_idx, off_d_r};
    back_wdata = cmd.init_step ? init_cnt_r[DATA_W-1:0] : cache_rdata_r;
  end

  always_ff @(posedge clk) begin
    if (cache_we) cache_mem[cache_waddr] <= cache_wdata;
    if (cache_re) cache_rdata_r <= cache_mem[cache_raddr];
  end

  always_ff @(posedge clk) begin
    if (back_we) back_mem[back_waddr] <= back_wdata;
    if (back_re) back_rdata_r <= back_mem[back_raddr];
  end

  // request, byte offset delay, result
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_cmd_r   <= in_cmd;
      req_addr_r  <= in_address;
      req_wdata_r <= in_write_data;
    end
    off_d_r <= cnt_r;
    if (cmd.out_load) begin
      out_data_r <= (req_cmd_r == dmwb_pkg::CMD_WRITE) ? req_wdata_r : cache_rdata_r;
      out_hit_r  <= !miss_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NLINES; i++) tags_r[i] <= '0;
      valid_r    <= '0;
      dirty_r    <= '0;
      miss_r     <= 1'b0;
      cnt_r      <= '0;
      spill_wr_r <= 1'b0;
      fill_wr_r  <= 1'b0;
      init_cnt_r <= '0;
    end else begin
      spill_wr_r <= cmd.spill_step;
      fill_wr_r  <= cmd.fill_step;
      if (cmd.init_step) init_cnt_r <= init_cnt_r + 1'b1;
      // counter wraps back to zero after the last byte of a line
      if (cmd.spill_step || cmd.fill_step) cnt_r <= cnt_r + 1'b1;
      if (cmd.req_load) miss_r <= 1'b0;
      else if (cmd.fill_step) miss_r <= 1'b1;
      if (cmd.fill_end) begin
        tags_r[req_idx]  <= req_tag;
        valid_r[req_idx] <= 1'b1;
        dirty_r[req_idx] <= 1'b0;
      end
      if (cmd.lookup && (req_cmd_r == dmwb_pkg::CMD_WRITE)) dirty_r[req_idx] <= 1'b1;
    end
  end

  assign out_read_data = out_data_r;
  assign out_hit       = out_hit_r;

endmodule

@@ rtl/core/direct_mapped_write_back_cache_core.sv @@
// Hit: lookup, then the result loads; the next request can be taken as it loads.
// Clean miss: a 16-byte line fill from the one-read-port backing RAM.
// Dirty miss: a 16-byte write-back of the victim line, then the fill.
// Reset (rst_n low, synchronous) clears tags, valid and dirty bits, then a
// pass over all 2048 bytes loads backing memory byte i with the low byte of i; no
// transaction is accepted until it finishes.
// ----------------------------------------------------------------------------
// direct_mapped_write_back_cache_core
// Direct-mapped, write-allocate, write-back byte cache (16 lines of 16
// bytes) in front of a 2 KB backing memory.
// ----------------------------------------------------------------------------
module direct_mapped_write_back_cache_core (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // [10:0] address, [18:11] write_data, [23:19] zero
  input  logic        in_tuser,  // [0] cmd (0 read, 1 write)
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // [7:0] read_data
  output logic        out_tuser  // [0] hit
);

  dmwb_pkg::dmwb_cmd_t cmd;
  dmwb_pkg::dmwb_sts_t sts;

  // Controller: sequences the power-up pass, lookup, victim write-back (read line
  // RAM, write backing RAM in the next cycle), fill, and the output register hand-off.
  dmwb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: line RAM, backing RAM, line state arrays and output register.
  dmwb_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_cmd        (in_tuser),
    .in_address    (in_tdata[dmwb_pkg::ADDR_W-1:0]),
    .in_write_data (in_tdata[dmwb_pkg::ADDR_W+dmwb_pkg::DATA_W-1:dmwb_pkg::ADDR_W]),
    .out_read_data (out_tdata),
    .out_hit       (out_tuser)
  );

endmodule

@@ sim/direct_mapped_write_back_cache_core_tb.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_write_back_cache_core_tb
// Self-checking bench for the byte cache core. A shadow copy of the lines,
// tags, valid/dirty bits and backing memory predicts read data and the hit
// flag for every accepted request. Directed cases cover cold misses, hits,
// dirty evictions and full-line write-back. Random traffic follows with
// bursty idling on both channels, then runs back to back to finish.
// ----------------------------------------------------------------------------
module direct_mapped_write_back_cache_core_tb;

  localparam int   ADDR_W      = dmwb_pkg::ADDR_W;
  localparam int   DATA_W      = dmwb_pkg::DATA_W;
  localparam int   OFF_W       = dmwb_pkg::OFF_W;
  localparam int   IDX_W       = dmwb_pkg::IDX_W;
  localparam int   TAG_W       = dmwb_pkg::TAG_W;
  localparam int   CACHE_AW    = dmwb_pkg::CACHE_AW;
  localparam int   CACHE_BYTES = dmwb_pkg::CACHE_BYTES;
  localparam int   LINE_SIZE   = dmwb_pkg::LINE_SIZE;
  localparam int   NUM_LINES   = dmwb_pkg::NUM_LINES;
  localparam int   MEM_SIZE    = dmwb_pkg::MEM_SIZE;
  localparam logic CMD_READ    = dmwb_pkg::CMD_READ;
  localparam logic CMD_WRITE   = dmwb_pkg::CMD_WRITE;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_LIMIT   = 8000;  // covers the power-up pass over all 2048 bytes
  localparam int DRAIN_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 40;    // longer than a dirty miss
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic              hit;
    logic              cmd;
    logic [ADDR_W-1:0] addr;
  } access_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;
  logic        out_tuser;

  bit idle_en = 1'b1;
  int err_count, quiet_cycles, stall_left;
  int read_count, write_count, hit_count, miss_count, spill_count;

  access_result_t awaited[$];
  access_result_t head;

  // shadow cache state
  logic [DATA_W-1:0] shadow_line  [CACHE_BYTES];
  logic [TAG_W-1:0]  shadow_tag   [NUM_LINES];
  bit                shadow_valid [NUM_LINES];
  bit                shadow_dirty [NUM_LINES];
  logic [DATA_W-1:0] shadow_mem   [MEM_SIZE];

  always #HALF_PERIOD clk = ~clk;

  direct_mapped_write_back_cache_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Miss: spill a dirty victim line in full, refill, install tag.
  function automatic access_result_t predict_access(input logic cmd,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [DATA_W-1:0] wdata);
    logic [OFF_W-1:0]    off;
    logic [IDX_W-1:0]    idx;
    logic [TAG_W-1:0]    tag;
    logic [CACHE_AW-1:0] slot;
    logic                hit;
    access_result_t      r;
    off  = addr[OFF_W-1:0];
    idx  = addr[OFF_W +: IDX_W];
    tag  = addr[ADDR_W-1 -: TAG_W];
    slot = {idx, off};
    hit  = shadow_valid[idx] && (shadow_tag[idx] == tag);
    if (!hit) begin
      miss_count++;
      if (shadow_valid[idx] && shadow_dirty[idx]) begin
        spill_count++;
        for (int k = 0; k < LINE_SIZE; k++)
          shadow_mem[{shadow_tag[idx], idx, OFF_W'(k)}] = shadow_line[{idx, OFF_W'(k)}];
      end
      for (int k = 0; k < LINE_SIZE; k++)
        shadow_line[{idx, OFF_W'(k)}] = shadow_mem[{tag, idx, OFF_W'(k)}];
      shadow_dirty[idx] = 1'b0;
      shadow_tag[idx]   = tag;
      shadow_valid[idx] = 1'b1;
    end else begin
      hit_count++;
    end
    if (cmd == CMD_WRITE) begin
      shadow_line[slot] = wdata;
      shadow_dirty[idx] = 1'b1;
      write_count++;
    end else begin
      read_count++;
    end
    r.data = shadow_line[slot];
    r.hit  = hit;
    r.cmd  = cmd;
    r.addr = addr;
    return r;
  endfunction

  // Leaves tvalid high after acceptance; the next call lowers it only for an idle gap, the drain lowers it.
  task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= 24'({wdata, addr});
    do @(posedge clk); while (!in_tready);
    awaited.push_back(predict_access(cmd, addr, wdata));
  endtask

  // Result channel: bursty back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result data=%02h hit=%0b with no access outstanding",
                                  out_tdata, out_tuser));
      end else begin
        head = awaited.pop_front();
        if (out_tdata !== head.data)
          report_mismatch($sformatf("%s addr=%03h: read_data %02h, want %02h",
                                    head.cmd ? "write" : "read", head.addr,
                                    out_tdata, head.data));
        if (out_tuser !== head.hit)
          report_mismatch($sformatf("%s addr=%03h: hit %0b, want %0b",
                                    head.cmd ? "write" : "read", head.addr,
                                    out_tuser, head.hit));
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("direct_mapped_write_back_cache_core_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_cold_and_hit();
    send_access(CMD_READ,  11'h000, 8'h00);  // cold miss
    send_access(CMD_READ,  11'h00F, 8'h00);  // hit, last offset
    send_access(CMD_WRITE, 11'h005, 8'hFF);  // write hit
    send_access(CMD_READ,  11'h005, 8'h00);
    send_access(CMD_READ,  11'h7FF, 8'h00);  // top address, cold miss
    send_access(CMD_WRITE, 11'h7FF, 8'h00);
  endtask

  task automatic test_dirty_victim();
    send_access(CMD_WRITE, 11'h100, 8'hA5);  // evicts dirty line 0
    send_access(CMD_READ,  11'h005, 8'h00);  // evicts dirty tag 1, reads back FF
    send_access(CMD_READ,  11'h100, 8'h00);  // clean eviction, reads back A5
    send_access(CMD_WRITE, 11'h2F0, 8'h3C);  // write miss over dirty line 15
    send_access(CMD_READ,  11'h7FF, 8'h00);
  endtask

  task automatic test_overwrite();
    send_access(CMD_WRITE, 11'h35A, 8'h80);
    send_access(CMD_WRITE, 11'h35A, 8'h01);
    send_access(CMD_READ,  11'h35A, 8'h00);
  endtask

  // Only two bytes dirty; untouched bytes must survive the write-back too.
  task automatic test_whole_line_writeback();
    send_access(CMD_WRITE, 11'h4C0, 8'h11);
    send_access(CMD_WRITE, 11'h4CF, 8'hEE);
    send_access(CMD_READ,  11'h0C7, 8'h00);
    send_access(CMD_READ,  11'h4C0, 8'h00);
    send_access(CMD_READ,  11'h4C7, 8'h00);
    send_access(CMD_READ,  11'h4CF, 8'h00);
  endtask

  // Mostly same-line locality, some same-index conflicts, some anywhere.
  // Idling is only varied when the caller left it enabled.
  task automatic test_locality_mix(input int n);
    logic [ADDR_W-1:0] addr;
    int                pick;
    bit                idle_base;
    idle_base = idle_en;
    addr = ADDR_W'($urandom_range(0, MEM_SIZE - 1));
    for (int i = 0; i < n; i++) begin
      if (idle_base && i % 100 == 0) idle_en = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 5)
        addr[OFF_W-1:0] = OFF_W'($urandom_range(0, LINE_SIZE - 1));
      else if (pick < 7)
        addr = {TAG_W'($urandom_range(0, 7)), addr[OFF_W +: IDX_W],
                OFF_W'($urandom_range(0, LINE_SIZE - 1))};
      else
        addr = ADDR_W'($urandom_range(0, MEM_SIZE - 1));
      send_access(logic'($urandom_range(0, 1)), addr, DATA_W'($urandom_range(0, 255)));
    end
    idle_en = idle_base;
  endtask

  // Two tags fight over one line, write-heavy: many dirty evictions.
  task automatic test_conflict_thrash(input int n);
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag_a, tag_b;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        idx   = IDX_W'($urandom_range(0, NUM_LINES - 1));
        tag_a = TAG_W'($urandom_range(0, 7));
        tag_b = TAG_W'($urandom_range(0, 7));
      end
      send_access(($urandom_range(0, 9) < 6) ? CMD_WRITE : CMD_READ,
                  {$urandom_range(0, 1) ? tag_a : tag_b, idx,
                   OFF_W'($urandom_range(0, LINE_SIZE - 1))},
                  DATA_W'($urandom_range(0, 255)));
    end
  endtask

  // Closing stretch: no idling on either side.
  task automatic test_back_to_back(input int n);
    idle_en = 1'b0;
    test_locality_mix(n);
    idle_en = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < MEM_SIZE; i++) shadow_mem[i] = DATA_W'(i);
    for (int i = 0; i < CACHE_BYTES; i++) shadow_line[i] = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      shadow_tag[i]   = '0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_cold_and_hit();
    test_dirty_victim();
    test_overwrite();
    test_whole_line_writeback();
    test_locality_mix(1000);
    test_conflict_thrash(330);
    test_back_to_back(300);

    in_tvalid <= 1'b0;
    idle_en = 1'b0;
    for (int w = 0; awaited.size() != 0 && w < DRAIN_LIMIT; w++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    while (awaited.size() != 0) begin
      head = awaited.pop_front();
      report_mismatch($sformatf("no result for %s addr=%03h",
                                head.cmd ? "write" : "read", head.addr));
    end

    $display("covered %0d accesses (%0d reads, %0d writes): %0d hits, %0d misses, %0d dirty evictions",
             read_count + write_count, read_count, write_count, hit_count, miss_count,
             spill_count);
    $display("directed line cases, locality mix and line thrash under bursty idling, then back to back");
    if (err_count == 0) begin
      $display("direct_mapped_write_back_cache_core_tb passed");
    end else begin
      $display("direct_mapped_write_back_cache_core_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/dmwb_pkg.sv
rtl/core/dmwb_ctrl.sv
rtl/core/dmwb_datapath.sv
rtl/core/direct_mapped_write_back_cache_core.sv
sim/direct_mapped_write_back_cache_core_tb.sv
